/* design/hct_pkg.sv */
package hct_pkg;

  // Fixed-point format and block constants
  localparam int FRAC_BITS    = 24;
  localparam int NUM_CARRIERS = 3;
  localparam int NEAR_ZERO    = 1;

  // Operating modes
  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_INV = 1'b1;

  // Arithmetic unit latencies
  localparam int MUL_LAT   = 2;
  localparam int DIV_STEPS = 128;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  // Pipeline schedule, in cycles from the accepted beat
  localparam int TERM_LAT = DIV_LAT + 7;
  localparam int T2_LAT   = TERM_LAT + 5 + DIV_LAT;
  localparam int OUT_LAT  = T2_LAT + 6 + DIV_LAT;

  // Configuration register indexes
  localparam logic [2:0] REG_DENS0 = 3'd0;
  localparam logic [2:0] REG_MOB0  = 3'd1;
  localparam logic [2:0] REG_DENS1 = 3'd2;
  localparam logic [2:0] REG_MOB1  = 3'd3;
  localparam logic [2:0] REG_DENS2 = 3'd4;
  localparam logic [2:0] REG_MOB2  = 3'd5;
  localparam logic [2:0] REG_GEOM  = 3'd6;
  localparam logic [2:0] REG_CUR   = 3'd7;

  localparam logic [30:0] GEOM_RESET = 31'(1 << FRAC_BITS);

  localparam logic signed [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'h8000_0000_0000;

  // Sign and zero-divisor info for one division
  typedef struct packed {
    logic neg;
    logic zero;
    logic satneg;
  } dflag_t;

  // One field point as it travels down the pipeline
  typedef struct packed {
    logic               mode;
    logic               last;
    logic               err;
    logic               nz;
    logic signed [47:0] xx;
    logic signed [47:0] xy;
    logic signed [47:0] s;
    logic signed [47:0] rh;
    logic signed [47:0] us;
    logic signed [47:0] uy;
    logic [127:0]       ss;
    logic [48:0]        t;
    dflag_t             fa;
    dflag_t             fb;
  } item_t;

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? (~v + 48'd1) : v;
  endfunction

  // Apply sign and saturate a magnitude to 48 bits
  function automatic logic signed [47:0] fin48(input logic neg, input logic [127:0] m);
    logic signed [47:0] r;
    if (neg) begin
      if (m >= 128'h8000_0000_0000) r = MIN48;
      else r = ~m[47:0] + 48'd1;
    end else begin
      if (m > 128'h7FFF_FFFF_FFFF) r = MAX48;
      else r = m[47:0];
    end
    return r;
  endfunction

  function automatic dflag_t mkflag(input logic neg, input logic [127:0] num,
                                    input logic [127:0] den);
    dflag_t f;
    f.neg    = neg;
    f.zero   = (den == '0);
    f.satneg = neg && (num != '0);
    return f;
  endfunction

  // Finish a quotient: saturate on a zero divisor, else sign and clamp
  function automatic logic signed [47:0] qfin(input dflag_t f, input logic [127:0] q);
    logic signed [47:0] r;
    if (f.zero) r = f.satneg ? MIN48 : MAX48;
    else r = fin48(f.neg, q);
    return r;
  endfunction

endpackage

/* design/hct_mul.sv */
module hct_mul (
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] p_r;

  // Form 32x32 partial products
  always_ff @(posedge clk) begin
    ll_r <= {32'd0, a[31:0]}  * {32'd0, b[31:0]};
    lh_r <= {32'd0, a[31:0]}  * {32'd0, b[63:32]};
    hl_r <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
    hh_r <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
  end

  // Sum the partial products
  always_ff @(posedge clk) begin
    p_r <= {hh_r, ll_r} + ({64'd0, lh_r} << 32) + ({64'd0, hl_r} << 32);
  end

  assign p = p_r;

endmodule

/* design/hct_div.sv */
module hct_div (
  input  logic         clk,
  input  logic [127:0] num,
  input  logic [127:0] den,
  output logic [127:0] quo
);

  logic [127:0] rem_r [hct_pkg::DIV_STEPS+1];
  logic [127:0] nq_r  [hct_pkg::DIV_STEPS+1];
  logic [127:0] den_r [hct_pkg::DIV_STEPS+1];
  logic [127:0] quo_r;

  // Load operands
  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    nq_r[0]  <= num;
    den_r[0] <= den;
  end

  // One restoring quotient bit per stage
  for (genvar i = 1; i <= hct_pkg::DIV_STEPS; i++) begin : g_step
    logic [128:0] rs;
    logic [128:0] df;
    logic         qb;
    assign rs = {rem_r[i-1], nq_r[i-1][127]};
    assign df = rs - {1'b0, den_r[i-1]};
    assign qb = ~df[128];

    always_ff @(posedge clk) begin
      rem_r[i] <= qb ? df[127:0] : rs[127:0];
      nq_r[i]  <= {nq_r[i-1][126:0], qb};
      den_r[i] <= den_r[i-1];
    end
  end

  // Round to nearest, ties away from zero
  always_ff @(posedge clk) begin
    if (rem_r[hct_pkg::DIV_STEPS] >=
        den_r[hct_pkg::DIV_STEPS] - rem_r[hct_pkg::DIV_STEPS]) begin
      quo_r <= nq_r[hct_pkg::DIV_STEPS] + 128'd1;
    end else begin
      quo_r <= nq_r[hct_pkg::DIV_STEPS];
    end
  end

  assign quo = quo_r;

endmodule

/* design/hct_term.sv */
module hct_term (
  input  logic               clk,
  input  logic signed [31:0] field,
  input  logic [46:0]        dens,
  input  logic signed [31:0] mob,
  output logic signed [63:0] tx,
  output logic signed [63:0] ty
);

  localparam int BNEG_LEN = hct_pkg::DIV_LAT + 6;

  logic [31:0]  umag, bmag;
  logic [127:0] a_p, nu_p, sq_p, lo_p, hi_p;
  logic [64:0]  a_rnd;
  logic [40:0]  a1_r;
  logic [127:0] d_r, ny_r;
  logic [127:0] qx, qy;
  logic         bneg_r [BNEG_LEN];
  logic [63:0]  cx, cy;
  logic signed [63:0] tx_r, ty_r;

  assign umag = mob[31] ? (~mob + 32'd1) : mob;
  assign bmag = field[31] ? (~field + 32'd1) : field;

  // |u|*|B| and density times |u|
  hct_mul u_mul_a (.clk(clk), .a({32'd0, bmag}), .b({32'd0, umag}), .p(a_p));
  hct_mul u_mul_n (.clk(clk), .a({17'd0, dens}), .b({32'd0, umag}), .p(nu_p));

  // Round u*B to the fraction width
  assign a_rnd = {1'b0, a_p[63:0]} + (65'd1 << (hct_pkg::FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    a1_r <= 41'(a_rnd >> hct_pkg::FRAC_BITS);
  end

  hct_mul u_mul_sq (.clk(clk), .a({23'd0, a1_r}), .b({23'd0, a1_r}), .p(sq_p));
  hct_mul u_mul_lo (.clk(clk), .a(nu_p[63:0]), .b({23'd0, a1_r}), .p(lo_p));
  hct_mul u_mul_hi (.clk(clk), .a(nu_p[127:64]), .b({23'd0, a1_r}), .p(hi_p));

  // Denominator 1+(uB)^2 and numerator n*u*(uB)
  always_ff @(posedge clk) begin
    d_r  <= (128'd1 << (2 * hct_pkg::FRAC_BITS)) + sq_p;
    ny_r <= lo_p + (hi_p << 64);
  end

  hct_div u_div_x (.clk(clk), .num(nu_p << hct_pkg::FRAC_BITS), .den(d_r), .quo(qx));
  hct_div u_div_y (.clk(clk), .num(ny_r), .den(d_r), .quo(qy));

  // Hold the field sign until the quotients arrive
  always_ff @(posedge clk) begin
    bneg_r[0] <= field[31];
    for (int k = 1; k < BNEG_LEN; k++) bneg_r[k] <= bneg_r[k-1];
  end

  // Clamp term magnitudes and put the signs back
  assign cx = (qx > (128'd1 << 61)) ? (64'd1 << 61) : qx[63:0];
  assign cy = (qy > (128'd1 << 61)) ? (64'd1 << 61) : qy[63:0];

  always_ff @(posedge clk) begin
    tx_r <= mob[31] ? (~cx + 64'd1) : cx;
    ty_r <= bneg_r[BNEG_LEN-1] ? (~cy + 64'd1) : cy;
  end

  assign tx = tx_r;
  assign ty = ty_r;

endmodule

/* design/hall_conductivity_tensor_model_top.sv */
// Each accepted beat reaches its out_valid strobe through the same pipeline in both modes.
// Throughput: one field point per cycle; busy stays low and start is taken every cycle.
// Most of the latency comes from three levels of 128-step pipelined restoring dividers in series.
// Reset (synchronous, rst_n low) returns the configuration and valid registers to their reset
// values and drops any points in flight; results leave on a one-cycle strobe, the receiver cannot stall.
module hall_conductivity_tensor_model_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [31:0] in_field,
  input  logic signed [47:0] in_long_voltage_in,
  input  logic signed [47:0] in_hall_voltage_in,
  input  logic               in_last_point,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [46:0]        cfg_data,
  output logic               out_valid,
  output logic signed [47:0] out_cond_xx,
  output logic signed [47:0] out_cond_xy,
  output logic signed [47:0] out_eff_conductivity,
  output logic signed [47:0] out_eff_hall_coeff,
  output logic signed [47:0] out_long_voltage,
  output logic signed [47:0] out_hall_voltage,
  output logic               out_div_error,
  output logic               out_last_out
);

  localparam int NC   = hct_pkg::NUM_CARRIERS;
  localparam int ML   = hct_pkg::MUL_LAT;
  localparam int DL   = hct_pkg::DIV_LAT;
  localparam int TL   = hct_pkg::TERM_LAT;
  localparam int OL   = hct_pkg::OUT_LAT;
  localparam int F    = hct_pkg::FRAC_BITS;

  // Configuration registers
  logic [46:0]        dens_r [3];
  logic signed [31:0] mob_r  [3];
  logic [30:0]        geom_r;
  logic [46:0]        cur_r;

  logic [OL-1:0]  vld_r;
  hct_pkg::item_t in_item;
  hct_pkg::item_t sb_r [TL];
  hct_pkg::item_t sta_nxt, sta_r;
  hct_pkg::item_t stb_r [ML];
  hct_pkg::item_t stc_nxt, stc_r;
  hct_pkg::item_t std_nxt;
  hct_pkg::item_t std_r [DL];
  hct_pkg::item_t ste_nxt, ste_r;
  hct_pkg::item_t stf_r [ML];
  hct_pkg::item_t stg_nxt, stg_r;
  hct_pkg::item_t sth_r [ML];
  hct_pkg::item_t stj_nxt;
  hct_pkg::item_t stj_r [DL];
  hct_pkg::item_t out_nxt, out_r;

  logic signed [63:0] tx [NC];
  logic signed [63:0] ty [NC];
  logic signed [63:0] sxx, sxy;
  logic [127:0] gc_p, pxx_p, pxy_p, pr_p, ptt_p, pst_p;
  logic [127:0] n2a, d2a, n2b, d2b, q2a, q2b;
  logic [127:0] n3a, d3a, n3b, d3b, q3a, q3b;
  logic [127:0] r1, e3;
  logic [47:0]  mus, muy, mxx, mxy, ms3;
  logic [63:0]  mr_b;

  assign busy = 1'b0;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        dens_r[j] <= '0;
        mob_r[j]  <= '0;
      end
      geom_r <= hct_pkg::GEOM_RESET;
      cur_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hct_pkg::REG_DENS0: dens_r[0] <= cfg_data;
        hct_pkg::REG_MOB0:  mob_r[0]  <= cfg_data[31:0];
        hct_pkg::REG_DENS1: dens_r[1] <= cfg_data;
        hct_pkg::REG_MOB1:  mob_r[1]  <= cfg_data[31:0];
        hct_pkg::REG_DENS2: dens_r[2] <= cfg_data;
        hct_pkg::REG_MOB2:  mob_r[2]  <= cfg_data[31:0];
        hct_pkg::REG_GEOM:  geom_r    <= cfg_data[30:0];
        hct_pkg::REG_CUR:   cur_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Geometry ratio times current, static between writes
  hct_mul u_mul_gc (.clk(clk), .a({33'd0, geom_r}), .b({17'd0, cur_r}), .p(gc_p));

  // Per-carrier tensor terms
  for (genvar j = 0; j < NC; j++) begin : g_term
    hct_term u_term (
      .clk(clk), .field(in_field), .dens(dens_r[j]), .mob(mob_r[j]),
      .tx(tx[j]), .ty(ty[j])
    );
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[OL-2:0], start & ~busy};
  end

  always_comb begin
    in_item      = '0;
    in_item.mode = in_mode;
    in_item.last = in_last_point;
    in_item.us   = in_long_voltage_in;
    in_item.uy   = in_hall_voltage_in;
  end

  // Hold the beat while the carrier terms are formed
  always_ff @(posedge clk) begin
    sb_r[0] <= in_item;
    for (int k = 1; k < TL; k++) sb_r[k] <= sb_r[k-1];
  end

  // Sum carrier terms and saturate them in forward mode
  always_comb begin
    sxx = '0;
    sxy = '0;
    for (int j = 0; j < NC; j++) begin
      sxx = sxx + tx[j];
      sxy = sxy + ty[j];
    end
    sta_nxt = sb_r[TL-1];
    if (!sta_nxt.mode) begin
      sta_nxt.xx = hct_pkg::fin48(sxx[63], {64'd0, sxx[63] ? (~sxx + 64'd1) : sxx});
      sta_nxt.xy = hct_pkg::fin48(sxy[63], {64'd0, sxy[63] ? (~sxy + 64'd1) : sxy});
    end
  end

  always_ff @(posedge clk) begin
    sta_r <= sta_nxt;
  end

  // Squares of the tensor terms
  hct_mul u_mul_xx (.clk(clk), .a({16'd0, hct_pkg::mag48(sta_r.xx)}),
                    .b({16'd0, hct_pkg::mag48(sta_r.xx)}), .p(pxx_p));
  hct_mul u_mul_xy (.clk(clk), .a({16'd0, hct_pkg::mag48(sta_r.xy)}),
                    .b({16'd0, hct_pkg::mag48(sta_r.xy)}), .p(pxy_p));

  always_ff @(posedge clk) begin
    stb_r[0] <= sta_r;
    for (int k = 1; k < ML; k++) stb_r[k] <= stb_r[k-1];
  end

  // Attach the sum of squares
  always_comb begin
    stc_nxt    = stb_r[ML-1];
    stc_nxt.ss = pxx_p + pxy_p;
  end

  always_ff @(posedge clk) begin
    stc_r <= stc_nxt;
  end

  // Select operands for the second division level
  always_comb begin
    mxx = hct_pkg::mag48(stc_r.xx);
    mxy = hct_pkg::mag48(stc_r.xy);
    mus = hct_pkg::mag48(stc_r.us);
    muy = hct_pkg::mag48(stc_r.uy);
    std_nxt = stc_r;
    if (stc_r.mode) begin
      n2a = gc_p;
      d2a = {80'd0, mus};
      n2b = {80'd0, muy} << F;
      d2b = {81'd0, cur_r};
      std_nxt.fa = hct_pkg::mkflag(stc_r.us[47], n2a, d2a);
      std_nxt.fb = hct_pkg::mkflag(stc_r.uy[47], n2b, d2b);
      std_nxt.nz = (mus < 48'(hct_pkg::NEAR_ZERO));
    end else begin
      n2a = stc_r.ss;
      d2a = {80'd0, mxx};
      n2b = {80'd0, mxy} << (2 * F);
      d2b = stc_r.ss;
      std_nxt.fa = hct_pkg::mkflag(stc_r.xx[47], n2a, d2a);
      std_nxt.fb = hct_pkg::mkflag(stc_r.xy[47], n2b, d2b);
      std_nxt.nz = 1'b0;
    end
  end

  hct_div u_div_2a (.clk(clk), .num(n2a), .den(d2a), .quo(q2a));
  hct_div u_div_2b (.clk(clk), .num(n2b), .den(d2b), .quo(q2b));

  always_ff @(posedge clk) begin
    std_r[0] <= std_nxt;
    for (int k = 1; k < DL; k++) std_r[k] <= std_r[k-1];
  end

  // Finish effective conductivity and Hall coefficient
  always_comb begin
    ste_nxt     = std_r[DL-1];
    ste_nxt.s   = ste_nxt.nz ? '0 : hct_pkg::qfin(ste_nxt.fa, q2a);
    ste_nxt.rh  = hct_pkg::qfin(ste_nxt.fb, q2b);
    ste_nxt.err = ste_nxt.err | (ste_nxt.fa.zero & ~ste_nxt.nz) | ste_nxt.fb.zero;
  end

  always_ff @(posedge clk) begin
    ste_r <= ste_nxt;
  end

  // |R| times current (forward) or times |sigma| (inverse)
  assign mr_b = ste_r.mode ? {16'd0, hct_pkg::mag48(ste_r.s)} : {17'd0, cur_r};

  hct_mul u_mul_r (.clk(clk), .a({16'd0, hct_pkg::mag48(ste_r.rh)}), .b(mr_b), .p(pr_p));

  always_ff @(posedge clk) begin
    stf_r[0] <= ste_r;
    for (int k = 1; k < ML; k++) stf_r[k] <= stf_r[k-1];
  end

  // Round the product: Hall voltage or clamped Hall angle
  always_comb begin
    r1      = (pr_p + (128'd1 << (F - 1))) >> F;
    stg_nxt = stf_r[ML-1];
    if (stg_nxt.mode) begin
      stg_nxt.t = (r1 > (128'd1 << 48)) ? (49'd1 << 48) : r1[48:0];
    end else begin
      stg_nxt.uy = hct_pkg::fin48(stg_nxt.rh[47], r1);
      stg_nxt.t  = '0;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  hct_mul u_mul_tt (.clk(clk), .a({15'd0, stg_r.t}), .b({15'd0, stg_r.t}), .p(ptt_p));
  hct_mul u_mul_st (.clk(clk), .a({16'd0, hct_pkg::mag48(stg_r.s)}), .b({15'd0, stg_r.t}),
                    .p(pst_p));

  always_ff @(posedge clk) begin
    sth_r[0] <= stg_r;
    for (int k = 1; k < ML; k++) sth_r[k] <= sth_r[k-1];
  end

  // Select operands for the last division level
  always_comb begin
    ms3     = hct_pkg::mag48(sth_r[ML-1].s);
    e3      = (128'd1 << (2 * F)) + ptt_p;
    stj_nxt = sth_r[ML-1];
    if (stj_nxt.mode) begin
      n3a = {80'd0, ms3} << (2 * F);
      d3a = e3;
      n3b = pst_p << F;
      d3b = e3;
      stj_nxt.fa = hct_pkg::mkflag(stj_nxt.s[47], n3a, d3a);
      stj_nxt.fb = hct_pkg::mkflag(stj_nxt.rh[47], n3b, d3b);
    end else begin
      n3a = gc_p;
      d3a = {80'd0, ms3};
      n3b = '0;
      d3b = 128'd1;
      stj_nxt.fa = hct_pkg::mkflag(stj_nxt.s[47], n3a, d3a);
      stj_nxt.fb = '0;
    end
  end

  hct_div u_div_3a (.clk(clk), .num(n3a), .den(d3a), .quo(q3a));
  hct_div u_div_3b (.clk(clk), .num(n3b), .den(d3b), .quo(q3b));

  always_ff @(posedge clk) begin
    stj_r[0] <= stj_nxt;
    for (int k = 1; k < DL; k++) stj_r[k] <= stj_r[k-1];
  end

  // Finish tensor (inverse) or longitudinal voltage (forward)
  always_comb begin
    out_nxt = stj_r[DL-1];
    if (out_nxt.mode) begin
      out_nxt.xx  = hct_pkg::qfin(out_nxt.fa, q3a);
      out_nxt.xy  = hct_pkg::qfin(out_nxt.fb, q3b);
      out_nxt.err = out_nxt.err | out_nxt.fa.zero | out_nxt.fb.zero;
    end else begin
      out_nxt.us  = hct_pkg::qfin(out_nxt.fa, q3a);
      out_nxt.err = out_nxt.err | out_nxt.fa.zero;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid            = vld_r[OL-1];
  assign out_cond_xx          = out_r.xx;
  assign out_cond_xy          = out_r.xy;
  assign out_eff_conductivity = out_r.s;
  assign out_eff_hall_coeff   = out_r.rh;
  assign out_long_voltage     = out_r.us;
  assign out_hall_voltage     = out_r.uy;
  assign out_div_error        = out_r.err;
  assign out_last_out         = out_r.last;

  // Every accepted beat leaves after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(hct_pkg::OUT_LAT) out_valid)
    else $error("accepted beat did not produce a result on time");

  // No result without a beat accepted the fixed latency earlier
  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, hct_pkg::OUT_LAT))
    else $error("result strobe without a matching beat");

  // Sweep marker stays aligned with its point
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(hct_pkg::OUT_LAT) (out_last_out == $past(in_last_point, hct_pkg::OUT_LAT)))
    else $error("last marker out of step with its point");

  // Inverse mode echoes the measured voltages
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_mode |-> ##(hct_pkg::OUT_LAT)
      (out_long_voltage == $past(in_long_voltage_in, hct_pkg::OUT_LAT)) &&
      (out_hall_voltage == $past(in_hall_voltage_in, hct_pkg::OUT_LAT)))
    else $error("inverse voltages not carried through");

endmodule

/* sim/hct_checker.sv */
`timescale 1ns / 1ps

module hct_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_mode,
  input  logic signed [31:0] in_field,
  input  logic signed [47:0] in_long_voltage_in,
  input  logic signed [47:0] in_hall_voltage_in,
  input  logic               in_last_point,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [46:0]        cfg_data,
  input  logic               out_valid,
  input  logic signed [47:0] out_cond_xx,
  input  logic signed [47:0] out_cond_xy,
  input  logic signed [47:0] out_eff_conductivity,
  input  logic signed [47:0] out_eff_hall_coeff,
  input  logic signed [47:0] out_long_voltage,
  input  logic signed [47:0] out_hall_voltage,
  input  logic               out_div_error,
  input  logic               out_last_out,
  output int                 pending,
  output int                 errors
);

  localparam int F = hct_pkg::FRAC_BITS;

  typedef logic [127:0] u128_t;

  typedef struct {
    logic signed [47:0] xx;
    logic signed [47:0] xy;
    logic signed [47:0] sig;
    logic signed [47:0] rh;
    logic signed [47:0] vl;
    logic signed [47:0] vh;
    logic               err;
    logic               last;
  } point_t;

  // Register mirror
  logic [46:0]        dens_q [3];
  logic signed [31:0] mob_q  [3];
  logic [30:0]        geom_q;
  logic [46:0]        cur_q;

  point_t tensor_q[$];
  bit     zero_div;

  function automatic u128_t mag_of(longint v);
    u128_t m;
    m = (v < 0) ? u128_t'(-v) : u128_t'(v);
    return m;
  endfunction

  // Rounded quotient, ties away from zero on magnitudes
  function automatic u128_t rdiv(u128_t n, u128_t d);
    u128_t q, r;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return q;
  endfunction

  function automatic u128_t rshr(u128_t v);
    return (v + (u128_t'(1) << (F - 1))) >> F;
  endfunction

  function automatic logic signed [47:0] sat48(bit neg, u128_t m);
    logic signed [47:0] r;
    if (neg) r = (m >= (u128_t'(1) << 47)) ? hct_pkg::MIN48 : -$signed(m[47:0]);
    else r = (m > u128_t'(hct_pkg::MAX48)) ? hct_pkg::MAX48 : m[47:0];
    return r;
  endfunction

  // Divide with saturation; flag a zero divisor
  function automatic logic signed [47:0] sdiv(bit neg, u128_t num, u128_t den);
    logic signed [47:0] r;
    if (den == 0) begin
      zero_div = 1;
      r = (neg && num != 0) ? hct_pkg::MIN48 : hct_pkg::MAX48;
    end else begin
      r = sat48(neg, rdiv(num, den));
    end
    return r;
  endfunction

  function automatic point_t predict_point(logic mode, logic signed [31:0] fld,
                                           logic signed [47:0] lv, logic signed [47:0] hv,
                                           logic last);
    point_t p;
    longint b, u, sxx, sxy;
    u128_t gc, a1, d, nu, tx, ty, ss, t, e;
    gc = u128_t'(geom_q) * u128_t'(cur_q);
    zero_div = 0;
    if (mode == hct_pkg::MODE_FWD) begin
      b = fld;
      sxx = 0;
      sxy = 0;
      // Sum per-carrier tensor terms
      for (int j = 0; j < hct_pkg::NUM_CARRIERS; j++) begin
        u = mob_q[j];
        a1 = rshr(mag_of(u) * mag_of(b));
        d = (u128_t'(1) << (2 * F)) + a1 * a1;
        nu = u128_t'(dens_q[j]) * mag_of(u);
        tx = rdiv(nu << F, d);
        ty = rdiv(nu * a1, d);
        if (tx > (u128_t'(1) << 61)) tx = u128_t'(1) << 61;
        if (ty > (u128_t'(1) << 61)) ty = u128_t'(1) << 61;
        sxx += (u < 0) ? -longint'(tx) : longint'(tx);
        sxy += (b < 0) ? -longint'(ty) : longint'(ty);
      end
      p.xx = sat48(sxx < 0, mag_of(sxx));
      p.xy = sat48(sxy < 0, mag_of(sxy));
      ss = mag_of(p.xx) * mag_of(p.xx) + mag_of(p.xy) * mag_of(p.xy);
      p.sig = sdiv(p.xx < 0, ss, mag_of(p.xx));
      p.rh = sdiv(p.xy < 0, mag_of(p.xy) << (2 * F), ss);
      p.vl = sdiv(p.sig < 0, gc, mag_of(p.sig));
      p.vh = sat48(p.rh < 0, rshr(mag_of(p.rh) * u128_t'(cur_q)));
    end else begin
      p.vl = lv;
      p.vh = hv;
      if (mag_of(lv) < hct_pkg::NEAR_ZERO) p.sig = '0;
      else p.sig = sdiv(lv < 0, gc, mag_of(lv));
      p.rh = sdiv(hv < 0, mag_of(hv) << F, u128_t'(cur_q));
      // Clamp the Hall angle before it enters the denominator
      t = rshr(mag_of(p.rh) * mag_of(p.sig));
      if (t > (u128_t'(1) << 48)) t = u128_t'(1) << 48;
      e = (u128_t'(1) << (2 * F)) + t * t;
      p.xx = sdiv(p.sig < 0, mag_of(p.sig) << (2 * F), e);
      p.xy = sdiv(p.rh < 0, (mag_of(p.sig) * t) << F, e);
    end
    p.err = zero_div;
    p.last = last;
    return p;
  endfunction

  function automatic void cmp_field(string nm, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, nm, exp_v, act_v);
      errors++;
    end
  endfunction

  assign pending = tensor_q.size();

  always @(posedge clk) begin
    point_t p;
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        dens_q[j] <= '0;
        mob_q[j] <= '0;
      end
      geom_q <= hct_pkg::GEOM_RESET;
      cur_q <= '0;
      errors = 0;
      tensor_q.delete();
    end else begin
      // Mirror register writes
      if (cfg_we) begin
        case (cfg_index)
          hct_pkg::REG_DENS0: dens_q[0] <= cfg_data;
          hct_pkg::REG_MOB0:  mob_q[0] <= cfg_data[31:0];
          hct_pkg::REG_DENS1: dens_q[1] <= cfg_data;
          hct_pkg::REG_MOB1:  mob_q[1] <= cfg_data[31:0];
          hct_pkg::REG_DENS2: dens_q[2] <= cfg_data;
          hct_pkg::REG_MOB2:  mob_q[2] <= cfg_data[31:0];
          hct_pkg::REG_GEOM:  geom_q <= cfg_data[30:0];
          hct_pkg::REG_CUR:   cur_q <= cfg_data;
          default: ;
        endcase
      end
      // Compare each result beat with the oldest prediction
      if (out_valid) begin
        if (tensor_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual xx %h",
                   $realtime, out_cond_xx);
          errors++;
        end else begin
          p = tensor_q.pop_front();
          cmp_field("cond_xx", p.xx, out_cond_xx);
          cmp_field("cond_xy", p.xy, out_cond_xy);
          cmp_field("eff_conductivity", p.sig, out_eff_conductivity);
          cmp_field("eff_hall_coeff", p.rh, out_eff_hall_coeff);
          cmp_field("long_voltage", p.vl, out_long_voltage);
          cmp_field("hall_voltage", p.vh, out_hall_voltage);
          cmp_field("div_error", 48'(p.err), 48'(out_div_error));
          cmp_field("last_out", 48'(p.last), 48'(out_last_out));
        end
      end
      // Predict each accepted beat
      if (start && !busy)
        tensor_q.push_back(predict_point(in_mode, in_field, in_long_voltage_in,
                                         in_hall_voltage_in, in_last_point));
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam logic MODE_FWD = hct_pkg::MODE_FWD;
  localparam logic MODE_INV = hct_pkg::MODE_INV;
  localparam int   PHASES = 8;
  localparam int   PHASE_ITEMS = 141;
  localparam int   DRAIN = hct_pkg::OUT_LAT + 12;
  localparam int   STALL_LIMIT = 6000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic               in_mode = 0;
  logic signed [31:0] in_field = '0;
  logic signed [47:0] in_long_voltage_in = '0;
  logic signed [47:0] in_hall_voltage_in = '0;
  logic               in_last_point = 0;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = '0;
  logic [46:0]        cfg_data = '0;
  logic               out_valid;
  logic signed [47:0] out_cond_xx, out_cond_xy, out_eff_conductivity, out_eff_hall_coeff;
  logic signed [47:0] out_long_voltage, out_hall_voltage;
  logic               out_div_error, out_last_out;
  int                 pending, errors;
  int                 stall_cnt = 0;
  bit                 no_idle = 0;

  always #10 clk = ~clk;

  hall_conductivity_tensor_model_top i_dut (.*);

  hct_checker i_checker (.*);

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rnd48();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: v = $signed(v) >>> $urandom_range(0, 47);
      1: v = $signed(v) >>> $urandom_range(20, 40);
      default: ;
    endcase
    return v;
  endfunction

  // Hold one beat until the block takes it
  task automatic send_point(logic mode, logic signed [31:0] fld,
                            logic signed [47:0] lv, logic signed [47:0] hv, logic last);
    while (!no_idle && $urandom_range(0, 99) < 19) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_mode <= mode;
    in_field <= fld;
    in_long_voltage_in <= lv;
    in_hall_voltage_in <= hv;
    in_last_point <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_regs(logic [46:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_point();
    logic signed [31:0] fld;
    fld = $urandom;
    if ($urandom_range(0, 2) == 0) fld = fld >>> $urandom_range(0, 31);
    if ($urandom_range(0, 1) == 0)
      send_point(MODE_FWD, fld, rnd48(), rnd48(), 1'($urandom_range(0, 1)));
    else
      send_point(MODE_INV, fld, ($urandom_range(0, 15) == 0) ? 48'sd0 : rnd48(),
                 ($urandom_range(0, 15) == 0) ? 48'sd0 : rnd48(),
                 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [46:0] regs [8];
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset settings: zero current and zero densities exercise the zero-divisor cases
    send_point(MODE_FWD, 32'sd0, '0, '0, 0);
    send_point(MODE_INV, 32'sd0, 48'sd0, 48'sd5, 1);
    send_point(MODE_INV, 32'sd0, hct_pkg::MIN48, hct_pkg::MAX48, 0);
    drain();

    // Typical sample, then field and voltage extremes
    regs = '{47'h10_0000_0000, 47'h0100_0000, 47'h3_0000_0000, 47'h7F00_0000,
             47'h200_0000, 47'h7FFF_8000_0000, 47'h200_0000, 47'h1_0000_0000};
    write_regs(regs);
    send_point(MODE_FWD, 32'sd0, '0, '0, 0);
    send_point(MODE_FWD, 32'h7FFF_FFFF, '0, '0, 1);
    send_point(MODE_FWD, 32'h8000_0000, '0, '0, 0);
    send_point(MODE_FWD, 32'sh0100_0000, '0, '0, 0);
    send_point(MODE_FWD, -32'sh0100_0000, '0, '0, 0);
    send_point(MODE_FWD, 32'sd1, '0, '0, 0);
    send_point(MODE_INV, 32'h7FFF_FFFF, 48'sd0, 48'sd100, 0);
    send_point(MODE_INV, '0, 48'sd1, 48'sd1, 0);
    send_point(MODE_INV, '0, -48'sd1, -48'sd1, 1);
    send_point(MODE_INV, '0, hct_pkg::MAX48, hct_pkg::MIN48, 0);
    send_point(MODE_INV, '0, hct_pkg::MIN48, hct_pkg::MAX48, 0);
    send_point(MODE_INV, '0, 48'sh1_0000_0000, 48'sh7FFF_FFFF_FFFF, 0);
    send_point(MODE_INV, '0, 48'sh1_0000, 48'sh1_0000_0000_00, 1);
    drain();

    // Carriers cancel: zero cond_xx at zero field
    regs = '{47'h1_0000_0000, 47'h0100_0000, 47'h1_0000_0000, 47'h7F00_0000,
             47'h1_0000_0000, 47'h7F00_0000, 47'h0100_0000, 47'h7FFF_FFFF_FFFF};
    regs[3] = 47'hFF00_0000;
    regs[4] = '0;
    write_regs(regs);
    send_point(MODE_FWD, 32'sd0, '0, '0, 0);
    send_point(MODE_FWD, 32'sh0080_0000, '0, '0, 1);
    drain();

    // Random phases across extreme and random settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: regs = '{47'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF, 47'h7FFF_FFFF_FFFF, 47'h8000_0000,
                    47'h7FFF_FFFF_FFFF, 47'hFFFF_FFFF, 47'h7FFF_FFFF, 47'h7FFF_FFFF_FFFF};
        1: regs = '{default: '0};
        default: begin
          for (int i = 0; i < 8; i++) regs[i] = 47'(rnd48());
          for (int i = 1; i < 6; i += 2) regs[i] = 47'($urandom >> $urandom_range(0, 16));
          regs[hct_pkg::REG_GEOM] = 47'($urandom_range(0, 32'h7FFF_FFFF));
        end
      endcase
      write_regs(regs);
      no_idle = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) random_point();
      no_idle = 0;
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/hct_pkg.sv
design/hct_mul.sv
design/hct_div.sv
design/hct_term.sv
design/hall_conductivity_tensor_model_top.sv
sim/hct_checker.sv
sim/tb_top.sv
